// File: hw/rtl/mbtf_pkg.sv
// Package for the Modbus TCP request framer: request/response payload types,
// queue entry type, function codes and status codes. No dependencies.
package mbtf_pkg;

  // Function codes
  localparam logic [7:0] CMD_RAW        = 8'h00;
  localparam logic [7:0] CMD_READ_HOLD  = 8'h03;
  localparam logic [7:0] CMD_READ_INPUT = 8'h04;
  localparam logic [7:0] CMD_WRITE_MULT = 8'h10;

  // Frame layout
  localparam logic [7:0] READ_PDU_LEN   = 8'd6;
  localparam logic [7:0] WRITE_LEN_BIAS = 8'd7;
  localparam logic [3:0] READ_LAST_IDX  = 4'd11;
  localparam logic [3:0] WHDR_LAST_IDX  = 4'd12;

  // Default configuration
  localparam int unsigned MAX_WRITE_BYTES_DEF = 246;
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;

  typedef enum logic [1:0] {
    ST_FRAME   = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_STRAY   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_RAW   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    JOB_BYTE = 2'd0,
    JOB_READ = 2'd1,
    JOB_WHDR = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  command;
    logic [7:0]  unit_id;
    logic [15:0] start_address;
    logic [15:0] count;
    logic [7:0]  transaction;
    logic [31:0] time_seconds;
    logic [7:0]  payload_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic [1:0] status;
  } rsp_t;

  // One queue entry: a single result byte, a read frame or a write header
  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  byte_val;
    logic        last;
    status_e     status;
    logic [7:0]  unit_id;
    logic [7:0]  command;
    logic [15:0] start_address;
    logic [15:0] count;
    logic [7:0]  transaction;
  } job_t;

endpackage

// File: hw/rtl/mbtf_fifo.sv
// Register-based job queue between the framer front and back end.
// Depends on mbtf_pkg (job_t).
module mbtf_fifo #(
  parameter int unsigned DEPTH = mbtf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mbtf_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output mbtf_pkg::job_t head_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mbtf_pkg::job_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/mbtf_front.sv
// Front end of the framer: accepts requests, tracks payload state, and
// turns each request into at most one queue job. Depends on mbtf_pkg.
module mbtf_front #(
  parameter int unsigned MAX_WRITE_BYTES = mbtf_pkg::MAX_WRITE_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mbtf_pkg::req_t in_req_i,
  output logic           push_o,
  output mbtf_pkg::job_t push_data_o,
  input  logic           full_i
);

  mbtf_pkg::mode_e mode_q, mode_d;
  logic [15:0]     left_q, left_d;
  logic [2:0]      idx_q, idx_d;
  logic [31:0]     held_time_q, held_time_d;
  logic            override_q, override_d;
  logic [7:0]      sync_unit_q;
  logic            accept;
  logic [7:0]      pay_byte;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full_i;
  assign accept      = in_valid_i && !full_i;

  // Hold the time-sync unit id
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_unit_q <= '0;
    end else if (cfg_valid_i) begin
      sync_unit_q <= cfg_data_i;
    end
  end

  // Replace the first four write payload bytes with the time when enabled
  always_comb begin
    pay_byte = in_req_i.payload_byte;
    if (mode_q == mbtf_pkg::MODE_WRITE && override_q && !idx_q[2]) begin
      case (idx_q[1:0])
        2'd0:    pay_byte = held_time_q[15:8];
        2'd1:    pay_byte = held_time_q[7:0];
        2'd2:    pay_byte = held_time_q[31:24];
        default: pay_byte = held_time_q[23:16];
      endcase
    end
  end

  // Classify the request and build the job
  always_comb begin
    mode_d      = mode_q;
    left_d      = left_q;
    idx_d       = idx_q;
    held_time_d = held_time_q;
    override_d  = override_q;
    push_o      = 1'b0;

    push_data_o               = '0;
    push_data_o.kind          = mbtf_pkg::JOB_BYTE;
    push_data_o.status        = mbtf_pkg::ST_FRAME;
    push_data_o.unit_id       = in_req_i.unit_id;
    push_data_o.command       = in_req_i.command;
    push_data_o.start_address = in_req_i.start_address;
    push_data_o.count         = in_req_i.count;
    push_data_o.transaction   = in_req_i.transaction;

    if (accept) begin
      if (in_req_i.kind) begin
        push_o = 1'b1;
        if (mode_q == mbtf_pkg::MODE_IDLE || left_q == '0) begin
          // Flag a stray payload byte
          mode_d             = mbtf_pkg::MODE_IDLE;
          push_data_o.status = mbtf_pkg::ST_STRAY;
        end else begin
          push_data_o.byte_val = pay_byte;
          push_data_o.last     = (left_q == 16'd1);
          left_d               = left_q - 1'b1;
          idx_d                = idx_q[2] ? idx_q : idx_q + 1'b1;
          if (left_q == 16'd1) begin
            mode_d     = mbtf_pkg::MODE_IDLE;
            override_d = 1'b0;
          end
        end
      end else begin
        // Drop any unfinished frame
        mode_d     = mbtf_pkg::MODE_IDLE;
        left_d     = '0;
        idx_d      = '0;
        override_d = 1'b0;
        case (in_req_i.command)
          mbtf_pkg::CMD_READ_HOLD, mbtf_pkg::CMD_READ_INPUT: begin
            push_o           = 1'b1;
            push_data_o.kind = mbtf_pkg::JOB_READ;
          end
          mbtf_pkg::CMD_WRITE_MULT: begin
            if (in_req_i.count == '0) begin
              push_o = 1'b0;
            end else if (in_req_i.count > 16'(MAX_WRITE_BYTES)) begin
              push_o             = 1'b1;
              push_data_o.status = mbtf_pkg::ST_LEN_ERR;
            end else begin
              push_o           = 1'b1;
              push_data_o.kind = mbtf_pkg::JOB_WHDR;
              mode_d           = mbtf_pkg::MODE_WRITE;
              left_d           = in_req_i.count;
              held_time_d      = in_req_i.time_seconds;
              override_d       = (in_req_i.unit_id == sync_unit_q);
            end
          end
          mbtf_pkg::CMD_RAW: begin
            if (in_req_i.count != '0) begin
              mode_d = mbtf_pkg::MODE_RAW;
              left_d = in_req_i.count;
            end
          end
          default: begin
            push_o = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mbtf_pkg::MODE_IDLE;
      left_q      <= '0;
      idx_q       <= '0;
      held_time_q <= '0;
      override_q  <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      held_time_q <= held_time_d;
      override_q  <= override_d;
    end
  end

endmodule

// File: hw/rtl/mbtf_back.sv
// Back end of the framer: walks the queue head job byte by byte into a
// registered output. Depends on mbtf_pkg.
module mbtf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mbtf_pkg::job_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mbtf_pkg::rsp_t out_rsp_o
);

  logic [3:0]     idx_q, idx_d;
  logic           valid_q, valid_d;
  mbtf_pkg::rsp_t rsp_q, rsp_d;
  logic           adv;
  logic [3:0]     last_idx;
  logic [7:0]     sel_byte;
  logic [15:0]    regs;

  assign adv         = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;
  assign regs        = {1'b0, head_i.count[15:1]};

  // Pick the frame byte at the current index
  always_comb begin
    sel_byte = 8'h00;
    last_idx = '0;
    case (head_i.kind)
      mbtf_pkg::JOB_READ: begin
        last_idx = mbtf_pkg::READ_LAST_IDX;
        case (idx_q)
          4'd1:    sel_byte = head_i.transaction;
          4'd5:    sel_byte = mbtf_pkg::READ_PDU_LEN;
          4'd6:    sel_byte = head_i.unit_id;
          4'd7:    sel_byte = head_i.command;
          4'd8:    sel_byte = head_i.start_address[15:8];
          4'd9:    sel_byte = head_i.start_address[7:0];
          4'd10:   sel_byte = head_i.count[15:8];
          4'd11:   sel_byte = head_i.count[7:0];
          default: sel_byte = 8'h00;
        endcase
      end
      mbtf_pkg::JOB_WHDR: begin
        last_idx = mbtf_pkg::WHDR_LAST_IDX;
        case (idx_q)
          4'd5:    sel_byte = head_i.count[7:0] + mbtf_pkg::WRITE_LEN_BIAS;
          4'd6:    sel_byte = head_i.unit_id;
          4'd7:    sel_byte = mbtf_pkg::CMD_WRITE_MULT;
          4'd8:    sel_byte = head_i.start_address[15:8];
          4'd9:    sel_byte = head_i.start_address[7:0];
          4'd10:   sel_byte = regs[15:8];
          4'd11:   sel_byte = regs[7:0];
          4'd12:   sel_byte = head_i.count[7:0];
          default: sel_byte = 8'h00;
        endcase
      end
      default: begin
        last_idx = '0;
        sel_byte = head_i.byte_val;
      end
    endcase
  end

  // Advance through the job and load the output register
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    rsp_d   = rsp_q;
    pop_o   = 1'b0;
    if (adv) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        rsp_d.frame_byte = sel_byte;
        rsp_d.status     = head_i.status;
        rsp_d.last       = (head_i.kind == mbtf_pkg::JOB_READ) ? (idx_q == last_idx)
                         : (head_i.kind == mbtf_pkg::JOB_BYTE) ? head_i.last : 1'b0;
        if (idx_q == last_idx) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

endmodule

// File: hw/rtl/modbus_tcp_request_framer.sv
// Top level of the Modbus TCP request framer: front end, job queue, back end.
// Depends on mbtf_pkg, mbtf_front, mbtf_fifo and mbtf_back.
//
//   Port group  Dir  Handshake              Payload
//   in_*        in   in_valid_i/in_stall_o  in_req_i  (mbtf_pkg::req_t)
//   out_*       out  out_valid_o/out_stall_i out_rsp_o (mbtf_pkg::rsp_t)
//   cfg_*       in   cfg_valid_i/cfg_ready_o cfg_data_i (time-sync unit id)
//
// One request is taken per cycle while the job queue has room; one frame
// byte leaves per cycle while out_stall_i is low. A read header is 12 bytes,
// a write header 13, a payload byte or error one; the output port sets the rate.
// The queue holds QUEUE_DEPTH jobs; in_stall_o rises when it is full.
// Reset clears all control state at once; no clearing pass.
module modbus_tcp_request_framer #(
  parameter int unsigned MAX_WRITE_BYTES = mbtf_pkg::MAX_WRITE_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = mbtf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mbtf_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mbtf_pkg::rsp_t out_rsp_o
);

  logic           push, pop, full, empty;
  mbtf_pkg::job_t push_data, head;

  mbtf_front #(
    .MAX_WRITE_BYTES(MAX_WRITE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  mbtf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  mbtf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
